### hdl/ncf_pkg.sv
// Package for the notification chunk framer.
// Holds the result word type, the per-item result bundle and the MTU constants.
// No dependencies.
package ncf_pkg;

  // MTU handling
  localparam logic [9:0] MAX_MTU     = 10'd517;
  localparam logic [9:0] DEFAULT_MTU = 10'd23;
  localparam logic [9:0] SMALL_MTU   = 10'd9;
  localparam logic [9:0] ATT_HDR     = 10'd3;
  localparam logic [9:0] SMALL_CAP   = 10'd20;
  localparam logic [9:0] FIRST_HDR   = 10'd6;
  localparam logic [9:0] LATER_HDR   = 10'd4;

  // Up to seven output words per input word
  localparam int RES_MAX = 7;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
    logic       message_end;
  } word_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    word_t [RES_MAX-1:0]       words;
  } result_t;

endpackage

### hdl/ncf_core.sv
// Framing core: message state, MTU register and per-word result build.
// Produces the full set of output words for one accepted input word.
// Depends on ncf_pkg.
module ncf_core
  import ncf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic [15:0] message_length,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  output result_t     result
);

  logic [9:0]  link_mtu;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  echo_high, echo_high_next;
  logic [7:0]  echo_low, echo_low_next;
  logic [15:0] chunk_number, chunk_number_next;
  logic [9:0]  slice_fill, slice_fill_next;
  logic        in_first_chunk, in_first_chunk_next;

  logic [9:0]  mtu, cap, max_slice, fill_inc;
  logic [15:0] body_len;
  logic        last, close, hdr;
  word_t       body_word;

  // Derive the chunk cap from the current MTU, plus the body length and the last-byte, chunk-close and header flags
  always_comb begin
    mtu       = (link_mtu > MAX_MTU) ? MAX_MTU : link_mtu;
    cap       = (mtu > SMALL_MTU) ? (mtu - ATT_HDR) : SMALL_CAP;
    max_slice = in_first_chunk ? (cap - FIRST_HDR) : (cap - LATER_HDR);
    body_len  = message_length - 16'd2;
    last      = ({1'b0, byte_position} + 17'd1) >= {1'b0, message_length};
    fill_inc  = slice_fill + 10'd1;
    close     = last || (fill_inc >= max_slice);
    hdr       = (slice_fill == 10'd0);
  end

  // Next message state and the result words
  always_comb begin
    byte_position_next  = byte_position;
    echo_high_next      = echo_high;
    echo_low_next       = echo_low;
    chunk_number_next   = chunk_number;
    slice_fill_next     = slice_fill;
    in_first_chunk_next = in_first_chunk;
    result              = '0;
    body_word.data        = data_byte;
    body_word.chunk_end   = close;
    body_word.message_end = last;

    if (message_length < 16'd2) begin
      byte_position_next  = '0;
      chunk_number_next   = '0;
      slice_fill_next     = '0;
      in_first_chunk_next = 1'b1;
    end else if (byte_position == 16'd0) begin
      echo_high_next     = data_byte;
      byte_position_next = 16'd1;
    end else if (byte_position == 16'd1) begin
      echo_low_next = data_byte;
      if (message_length == 16'd2) begin
        byte_position_next  = '0;
        chunk_number_next   = '0;
        slice_fill_next     = '0;
        in_first_chunk_next = 1'b1;
      end else begin
        byte_position_next = 16'd2;
      end
    end else begin
      // Header words first, body word last
      if (hdr) begin
        result.words[0] = '{data: echo_high, chunk_end: 1'b0, message_end: 1'b0};
        result.words[1] = '{data: echo_low, chunk_end: 1'b0, message_end: 1'b0};
        result.words[2] = '{data: chunk_number[7:0], chunk_end: 1'b0, message_end: 1'b0};
        result.words[3] = '{data: chunk_number[15:8], chunk_end: 1'b0, message_end: 1'b0};
        if (in_first_chunk) begin
          result.words[4] = '{data: body_len[7:0], chunk_end: 1'b0, message_end: 1'b0};
          result.words[5] = '{data: body_len[15:8], chunk_end: 1'b0, message_end: 1'b0};
          result.words[6] = body_word;
          result.count    = CNT_W'(7);
        end else begin
          result.words[4] = body_word;
          result.count    = CNT_W'(5);
        end
      end else begin
        result.words[0] = body_word;
        result.count    = CNT_W'(1);
      end

      if (last) begin
        byte_position_next  = '0;
        chunk_number_next   = '0;
        slice_fill_next     = '0;
        in_first_chunk_next = 1'b1;
      end else begin
        byte_position_next = byte_position + 16'd1;
        slice_fill_next    = fill_inc;
        if (close) begin
          slice_fill_next     = '0;
          chunk_number_next   = chunk_number + 16'd1;
          in_first_chunk_next = 1'b0;
        end
      end
    end
  end

  // MTU register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mtu <= DEFAULT_MTU;
    end else if (cfg_wr_en) begin
      link_mtu <= cfg_wr_data;
    end
  end

  // Advance message state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      echo_high      <= '0;
      echo_low       <= '0;
      chunk_number   <= '0;
      slice_fill     <= '0;
      in_first_chunk <= 1'b1;
    end else if (take) begin
      byte_position  <= byte_position_next;
      echo_high      <= echo_high_next;
      echo_low       <= echo_low_next;
      chunk_number   <= chunk_number_next;
      slice_fill     <= slice_fill_next;
      in_first_chunk <= in_first_chunk_next;
    end
  end

endmodule

### hdl/ncf_out.sv
// Result register and output shifter for the notification chunk framer.
// Holds up to seven words and hands them out one per accepted transfer.
// Depends on ncf_pkg.
module ncf_out
  import ncf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    result,
  output logic       in_ready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output word_t      head
);

  logic [CNT_W-1:0] cnt, cnt_next;
  word_t            words [RES_MAX];
  logic             pop;

  assign m_tvalid = (cnt != '0);
  assign pop      = m_tvalid && m_tready;
  assign in_ready = (cnt == '0) || ((cnt == CNT_W'(1)) && m_tready);
  assign head     = words[0];

  // Next fill level
  always_comb begin
    cnt_next = cnt;
    if (load) begin
      cnt_next = result.count;
    end else if (pop) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Load a fresh set or shift towards the head
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_MAX; i++) begin
        words[i] <= result.words[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

endmodule

### hdl/notification_chunk_framer_unit.sv
// Top level of the notification chunk framer.
// Instantiates the framing core and the output shifter; depends on ncf_pkg.
//
// Usage:
//   Input stream: one message byte per word, tdata = {message_length, data_byte}.
//   The first two bytes of a message are the echo word and give no output.
//   Each body byte gives one output word; the first body byte of a chunk is
//   preceded by four header words (six on the first chunk of a message).
//   Output stream: tdata carries the byte, tlast marks the last byte of a
//   notification, tuser marks the last byte of the whole message.
//   cfg_wr_en / cfg_wr_data write the link MTU (reset value 23) while idle.
// Timing: the first output word of an input word is registered and appears in the
//   cycle after the input word is accepted.
// Throughput: one input word per cycle while bodies stream and m_tready stays
//   high; an input word that opens a chunk blocks the input side until the
//   single-word output port has drained the header words.
// Reset: rst (synchronous) empties the output register, restarts the message
//   state, clears the echo word and restores the MTU.
// Stall: while the receiver holds m_tready low the current word is held and
//   s_tready drops once no further result can be taken in.
module notification_chunk_framer_unit
  import ncf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [7:0] data_byte, [23:8] message_length
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,    // chunk_end
  output logic [0:0]  m_tuser,    // [0] message_end
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  result_t result;
  word_t   head;
  logic    take;

  assign take = s_tvalid && s_tready;

  ncf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (s_tdata[7:0]),
    .message_length (s_tdata[23:8]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .result         (result)
  );

  ncf_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .result   (result),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata    = head.data;
  assign m_tlast    = head.chunk_end;
  assign m_tuser[0] = head.message_end;

endmodule

### hdl/ncf_checker.sv
// Port-level checks for the notification chunk framer.
// Bound to notification_chunk_framer_unit; no package dependency.
module ncf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  // Output empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // A stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser)))
    else $error("stalled output word changed");

  // End of message also ends the notification
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("message end without chunk end");

  // Empty output always takes input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind notification_chunk_framer_unit ncf_checker u_ncf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
